// ===== sv/dfdbm_pkg.sv =====
package dfdbm_pkg;

    localparam int BYTE_W = 8;
    localparam int DIST_W = 16;
    localparam int BAR_W  = 10;
    localparam int PROD_W = DIST_W + BAR_W;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int STS_W  = 2;
    localparam int POS_W  = 2;
    localparam int CNT_W  = 4;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    localparam logic [STS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STS_W-1:0] STATUS_CHKSUM = 2'd1;
    localparam logic [STS_W-1:0] STATUS_HEADER = 2'd2;

    localparam logic [IDX_W-1:0] REG_MIN_DISTANCE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_DISTANCE = 2'd1;
    localparam logic [IDX_W-1:0] REG_BAR_PIXELS   = 2'd2;

    localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 16'd250;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 16'd7500;
    localparam logic [BAR_W-1:0]  BAR_PIXELS_RST   = 10'd300;

    localparam logic [POS_W-1:0] POS_HEADER = 2'd0;
    localparam logic [POS_W-1:0] POS_HIGH   = 2'd1;
    localparam logic [POS_W-1:0] POS_LOW    = 2'd2;
    localparam logic [POS_W-1:0] POS_CHKSUM = 2'd3;

    // The quotient is always below the bar length, so one step per bar bit suffices.
    localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(BAR_W - 1);

    typedef struct packed {
        logic cap_header;
        logic cap_high;
        logic cap_low;
        logic cap_chksum;
        logic mul_load;
        logic div_step;
        logic load_out;
    } dfdbm_cmd_t;

    typedef struct packed {
        logic need_div;
    } dfdbm_sts_t;

endpackage

// ===== sv/dfdbm_ctrl.sv =====
module dfdbm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  dfdbm_pkg::dfdbm_sts_t  sts,
    output dfdbm_pkg::dfdbm_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [dfdbm_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [dfdbm_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            s_accept;

    // A frame's last byte is held off while the previous result is still waiting.
    assign s_ready  = (state_reg == ST_IDLE) &&
                      !(m_valid_reg && (pos_reg == dfdbm_pkg::POS_CHKSUM));
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd            = '0;
        cmd.cap_header = s_accept && (pos_reg == dfdbm_pkg::POS_HEADER);
        cmd.cap_high   = s_accept && (pos_reg == dfdbm_pkg::POS_HIGH);
        cmd.cap_low    = s_accept && (pos_reg == dfdbm_pkg::POS_LOW);
        cmd.cap_chksum = s_accept && (pos_reg == dfdbm_pkg::POS_CHKSUM);
        cmd.mul_load   = (state_reg == ST_CHECK) && sts.need_div;
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.load_out   = ((state_reg == ST_CHECK) && !sts.need_div) ||
                         (state_reg == ST_FINISH);
    end

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == dfdbm_pkg::POS_CHKSUM) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                cnt_next = '0;
                if (sts.need_div) begin
                    state_next = ST_DIV;
                end else begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == dfdbm_pkg::DIV_LAST_STEP) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== sv/dfdbm_dp.sv =====
module dfdbm_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dfdbm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dfdbm_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [dfdbm_pkg::BYTE_W-1:0]  s_rx_byte,
    input  dfdbm_pkg::dfdbm_cmd_t         cmd,
    output dfdbm_pkg::dfdbm_sts_t         sts,
    output logic [dfdbm_pkg::STS_W-1:0]   m_status,
    output logic [dfdbm_pkg::DIST_W-1:0]  m_range_mm,
    output logic [dfdbm_pkg::BAR_W-1:0]   m_fill_length,
    output logic                          m_changed
);

    logic [dfdbm_pkg::DIST_W-1:0]  min_reg, max_reg;
    logic [dfdbm_pkg::BAR_W-1:0]   bar_reg;
    logic [dfdbm_pkg::BYTE_W-1:0]  header_reg, high_reg, low_reg, chksum_reg;
    logic [dfdbm_pkg::DIST_W-1:0]  last_dist_reg;
    logic                          last_seen_reg;
    logic [dfdbm_pkg::DIST_W-1:0]  rem_reg, rem_next;
    logic [dfdbm_pkg::BAR_W-1:0]   quo_reg, quo_next;
    logic [dfdbm_pkg::STS_W-1:0]   status_reg;
    logic [dfdbm_pkg::DIST_W-1:0]  dist_out_reg;
    logic [dfdbm_pkg::BAR_W-1:0]   fill_out_reg;
    logic                          changed_out_reg;

    logic [dfdbm_pkg::DIST_W-1:0]  frame_mm;
    logic [dfdbm_pkg::BYTE_W-1:0]  sum;
    logic                          header_ok, chksum_ok, range_ok;
    logic [dfdbm_pkg::DIST_W-1:0]  span, offset;
    logic [dfdbm_pkg::PROD_W-1:0]  product;
    logic [dfdbm_pkg::DIST_W:0]    trial, trial_diff;
    logic                          trial_ge;
    logic [dfdbm_pkg::BAR_W-1:0]   fill;

    assign frame_mm  = {high_reg, low_reg};
    assign sum       = header_reg + high_reg + low_reg;
    assign header_ok = (header_reg == dfdbm_pkg::SYNC_BYTE);
    assign chksum_ok = (sum == chksum_reg);
    assign range_ok  = (max_reg > min_reg) && (frame_mm > min_reg) && (frame_mm < max_reg);
    assign span      = max_reg - min_reg;
    assign offset    = frame_mm - min_reg;
    assign product   = offset * bar_reg;

    assign sts.need_div = header_ok && chksum_ok && range_ok;

    // Restoring divider: one quotient bit per step, dividend bits shift out of quo_reg.
    assign trial      = {rem_reg, quo_reg[dfdbm_pkg::BAR_W-1]};
    assign trial_diff = trial - {1'b0, span};
    assign trial_ge   = (trial >= {1'b0, span});

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.mul_load) begin
            rem_next = product[dfdbm_pkg::PROD_W-1:dfdbm_pkg::BAR_W];
            quo_next = product[dfdbm_pkg::BAR_W-1:0];
        end else if (cmd.div_step) begin
            rem_next = trial_ge ? trial_diff[dfdbm_pkg::DIST_W-1:0]
                                : trial[dfdbm_pkg::DIST_W-1:0];
            quo_next = {quo_reg[dfdbm_pkg::BAR_W-2:0], trial_ge};
        end
    end

    always_comb begin
        if (range_ok) begin
            fill = quo_reg;
        end else if ((max_reg > min_reg) && (frame_mm >= max_reg)) begin
            fill = bar_reg;
        end else begin
            fill = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg       <= dfdbm_pkg::MIN_DISTANCE_RST;
            max_reg       <= dfdbm_pkg::MAX_DISTANCE_RST;
            bar_reg       <= dfdbm_pkg::BAR_PIXELS_RST;
            header_reg    <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            last_dist_reg <= '0;
            last_seen_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    dfdbm_pkg::REG_MIN_DISTANCE: min_reg <= cfg_wdata;
                    dfdbm_pkg::REG_MAX_DISTANCE: max_reg <= cfg_wdata;
                    dfdbm_pkg::REG_BAR_PIXELS:   bar_reg <= cfg_wdata[dfdbm_pkg::BAR_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.cap_header) begin
                header_reg <= s_rx_byte;
            end
            if (cmd.cap_high) begin
                high_reg <= s_rx_byte;
            end
            if (cmd.cap_low) begin
                low_reg <= s_rx_byte;
            end
            if (cmd.load_out && header_ok && chksum_ok) begin
                last_dist_reg <= frame_mm;
                last_seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.cap_chksum) begin
            chksum_reg <= s_rx_byte;
        end
        if (cmd.load_out) begin
            status_reg      <= dfdbm_pkg::STATUS_OK;
            dist_out_reg    <= '0;
            fill_out_reg    <= '0;
            changed_out_reg <= 1'b0;
            if (!header_ok) begin
                status_reg <= dfdbm_pkg::STATUS_HEADER;
            end else if (!chksum_ok) begin
                status_reg <= dfdbm_pkg::STATUS_CHKSUM;
            end else begin
                dist_out_reg    <= frame_mm;
                fill_out_reg    <= fill;
                changed_out_reg <= !last_seen_reg || (frame_mm != last_dist_reg);
            end
        end
    end

    assign m_status      = status_reg;
    assign m_range_mm    = dist_out_reg;
    assign m_fill_length = fill_out_reg;
    assign m_changed     = changed_out_reg;

endmodule

// ===== sv/distance_frame_decoder_bar_mapper_unit.sv =====
// Decodes four-byte sensor frames (0xFF header, distance high, distance low,
// checksum) from a byte stream, with no resynchronization: every fourth accepted
// byte closes a frame and produces one result transaction. The first three bytes
// of a frame are taken one per cycle while the block is idle. m_valid rises at
// the next edge after the one taking the last byte when the bar fill needs no
// division (bad frame, or distance at or outside the configured range), and
// otherwise after the ten-step restoring divider that maps the distance onto the
// bar. The output register lets the next frame's first three bytes enter while a
// result waits; its last byte is taken once the result has been accepted.
// Registers: 0 minimum distance, 1 maximum distance, 2 bar length in pixels;
// write them only while the block is idle.
module distance_frame_decoder_bar_mapper_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dfdbm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dfdbm_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dfdbm_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dfdbm_pkg::STS_W-1:0]   m_status,
    output logic [dfdbm_pkg::DIST_W-1:0]  m_range_mm,
    output logic [dfdbm_pkg::BAR_W-1:0]   m_fill_length,
    output logic                          m_changed
);

    dfdbm_pkg::dfdbm_cmd_t cmd;
    dfdbm_pkg::dfdbm_sts_t sts;

    dfdbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dfdbm_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_rx_byte     (s_rx_byte),
        .cmd           (cmd),
        .sts           (sts),
        .m_status      (m_status),
        .m_range_mm    (m_range_mm),
        .m_fill_length (m_fill_length),
        .m_changed     (m_changed)
    );

endmodule

// ===== sv/dfdbm_checker.sv =====
module dfdbm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [dfdbm_pkg::STS_W-1:0]   m_status,
    input logic [dfdbm_pkg::DIST_W-1:0]  m_range_mm,
    input logic [dfdbm_pkg::BAR_W-1:0]   m_fill_length,
    input logic                          m_changed
);

    // A result transaction that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_range_mm) && $stable(m_fill_length) && $stable(m_changed))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == dfdbm_pkg::STATUS_OK) ||
                    (m_status == dfdbm_pkg::STATUS_CHKSUM) ||
                    (m_status == dfdbm_pkg::STATUS_HEADER))
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != dfdbm_pkg::STATUS_OK) |->
        (m_range_mm == '0) && (m_fill_length == '0) && !m_changed)
        else $error("error result carries data");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind distance_frame_decoder_bar_mapper_unit dfdbm_checker u_dfdbm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_range_mm    (m_range_mm),
    .m_fill_length (m_fill_length),
    .m_changed     (m_changed)
);

// ===== tb/sv/tb.sv =====
module tb;

    localparam int BYTE_W = dfdbm_pkg::BYTE_W;
    localparam int DIST_W = dfdbm_pkg::DIST_W;
    localparam int BAR_W  = dfdbm_pkg::BAR_W;
    localparam int STS_W  = dfdbm_pkg::STS_W;
    localparam int IDX_W  = dfdbm_pkg::IDX_W;
    localparam int CFG_W  = dfdbm_pkg::CFG_W;
    localparam int POS_W  = dfdbm_pkg::POS_W;

    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [DIST_W-1:0] range_mm;
        logic [BAR_W-1:0]  fill_length;
        logic              changed;
    } frame_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [STS_W-1:0]  m_status;
    logic [DIST_W-1:0] m_range_mm;
    logic [BAR_W-1:0]  m_fill_length;
    logic              m_changed;

    distance_frame_decoder_bar_mapper_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_range_mm    (m_range_mm),
        .m_fill_length (m_fill_length),
        .m_changed     (m_changed)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Decoder state as the block should hold it.
    logic [DIST_W-1:0] cur_min      = dfdbm_pkg::MIN_DISTANCE_RST;
    logic [DIST_W-1:0] cur_max      = dfdbm_pkg::MAX_DISTANCE_RST;
    logic [BAR_W-1:0]  cur_bar      = dfdbm_pkg::BAR_PIXELS_RST;
    logic [POS_W-1:0]  frame_pos    = dfdbm_pkg::POS_HEADER;
    logic [BYTE_W-1:0] held_header  = '0;
    logic [BYTE_W-1:0] held_high    = '0;
    logic [BYTE_W-1:0] held_low     = '0;
    logic [DIST_W-1:0] last_good_mm = '0;
    logic              good_seen    = 1'b0;

    frame_result_t expected_frames[$];

    bit steady        = 1'b0;
    int rx_hold_req   = 0;
    int rx_hold_left  = 0;
    int rx_stall_left = 0;

    int bytes_sent    = 0;
    int mismatches    = 0;
    int ok_frames     = 0;
    int chksum_frames = 0;
    int header_frames = 0;

    function automatic logic [BAR_W-1:0] bar_fill(input logic [DIST_W-1:0] d);
        logic [31:0] scaled;
        if (cur_max <= cur_min || d <= cur_min)
            return '0;
        if (d >= cur_max)
            return cur_bar;
        scaled = ({16'd0, d} - {16'd0, cur_min}) * {22'd0, cur_bar};
        return BAR_W'(scaled / ({16'd0, cur_max} - {16'd0, cur_min}));
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        frame_result_t r;
        logic [BYTE_W-1:0] sum;
        logic [DIST_W-1:0] d;
        case (frame_pos)
            dfdbm_pkg::POS_HEADER: held_header = b;
            dfdbm_pkg::POS_HIGH:   held_high = b;
            dfdbm_pkg::POS_LOW:    held_low = b;
            default: begin
                r = '0;
                sum = held_header + held_high + held_low;
                // The header is judged first, so a frame bad in both reports the header.
                if (held_header != dfdbm_pkg::SYNC_BYTE) begin
                    r.status = dfdbm_pkg::STATUS_HEADER;
                end else if (sum != b) begin
                    r.status = dfdbm_pkg::STATUS_CHKSUM;
                end else begin
                    d = {held_high, held_low};
                    r.status      = dfdbm_pkg::STATUS_OK;
                    r.range_mm    = d;
                    r.fill_length = bar_fill(d);
                    r.changed     = !good_seen || (d != last_good_mm);
                    last_good_mm  = d;
                    good_seen     = 1'b1;
                end
                expected_frames.push_back(r);
            end
        endcase
        frame_pos = frame_pos + 1'b1;
    endfunction

    function automatic void check_frame();
        frame_result_t got;
        frame_result_t want;
        got = {m_status, m_range_mm, m_fill_length, m_changed};
        if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with none pending: status=%0d dist=%0d fill=%0d chg=%0d",
                         got.status, got.range_mm, got.fill_length, got.changed);
            return;
        end
        want = expected_frames.pop_front();
        case (want.status)
            dfdbm_pkg::STATUS_OK:     ok_frames++;
            dfdbm_pkg::STATUS_CHKSUM: chksum_frames++;
            default:                  header_frames++;
        endcase
        if (got.status !== want.status || got.range_mm !== want.range_mm ||
            got.fill_length !== want.fill_length || got.changed !== want.changed) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: expected status=%0d dist=%0d fill=%0d chg=%0d, ",
                          "got %0d %0d %0d %0d"},
                         want.status, want.range_mm, want.fill_length, want.changed,
                         got.status, got.range_mm, got.fill_length, got.changed);
        end
    endfunction

    // Register writes, accepted bytes and result transactions, in that order per edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    dfdbm_pkg::REG_MIN_DISTANCE: cur_min = cfg_wdata[DIST_W-1:0];
                    dfdbm_pkg::REG_MAX_DISTANCE: cur_max = cfg_wdata[DIST_W-1:0];
                    dfdbm_pkg::REG_BAR_PIXELS:   cur_bar = cfg_wdata[BAR_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                decode_byte(s_rx_byte);
            if (m_valid && m_ready)
                check_frame();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
            m_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_stall_left = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (!steady && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] h, hi, lo, ck);
        send_byte(h);
        send_byte(hi);
        send_byte(lo);
        send_byte(ck);
    endtask

    task automatic send_good(input logic [DIST_W-1:0] d);
        send_frame(dfdbm_pkg::SYNC_BYTE, d[DIST_W-1:BYTE_W], d[BYTE_W-1:0],
                   dfdbm_pkg::SYNC_BYTE + d[DIST_W-1:BYTE_W] + d[BYTE_W-1:0]);
    endtask

    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 9))
            0:       return cur_min;
            1:       return cur_min + 1'b1;
            2:       return cur_min - 1'b1;
            3:       return cur_max;
            4:       return cur_max - 1'b1;
            5:       return cur_max + 1'b1;
            6:       return last_good_mm;
            7:       return DIST_W'($urandom_range(cur_min, cur_max));
            default: return DIST_W'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        logic [DIST_W-1:0] d;
        logic [BYTE_W-1:0] h;
        logic [BYTE_W-1:0] sum;
        d   = pick_distance();
        h   = BYTE_W'($urandom);
        sum = dfdbm_pkg::SYNC_BYTE + d[DIST_W-1:BYTE_W] + d[BYTE_W-1:0];
        case ($urandom_range(0, 19))
            0: send_frame(h, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
            1: begin
                if (h == dfdbm_pkg::SYNC_BYTE)
                    h = ~dfdbm_pkg::SYNC_BYTE;
                send_frame(h, d[DIST_W-1:BYTE_W], d[BYTE_W-1:0],
                           ($urandom_range(0, 1) == 0) ? BYTE_W'(h + d[DIST_W-1:BYTE_W] +
                           d[BYTE_W-1:0]) : BYTE_W'($urandom));
            end
            2: send_frame(dfdbm_pkg::SYNC_BYTE, d[DIST_W-1:BYTE_W], d[BYTE_W-1:0],
                          sum ^ BYTE_W'($urandom_range(1, 255)));
            default: send_good(d);
        endcase
    endtask

    // Waits until every pending result has come back and the block has gone quiet.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [DIST_W-1:0] lo, hi, input logic [BAR_W-1:0] bar);
        cfg_wr_en <= 1'b1;
        cfg_index <= dfdbm_pkg::REG_MIN_DISTANCE;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= dfdbm_pkg::REG_MAX_DISTANCE;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= dfdbm_pkg::REG_BAR_PIXELS;
        cfg_wdata <= {(CFG_W-BAR_W)'($urandom), bar};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_setting(input logic [DIST_W-1:0] lo, hi, input logic [BAR_W-1:0] bar,
                               input int frames);
        configure(lo, hi, bar);
        repeat (frames) send_random_frame();
        settle();
    endtask

    task automatic test_directed_frames();
        send_good(16'd3875);
        send_good(16'd3875);
        send_good(16'd0);
        send_good(16'hFFFF);
        send_frame(8'h00, 8'h12, 8'h34, 8'h00);
        send_frame(dfdbm_pkg::SYNC_BYTE, 8'h01, 8'h02, 8'h55);
        send_good(16'd7499);
        settle();
    endtask

    task automatic test_config_extremes();
        run_setting(16'd0, 16'hFFFF, 10'd1023, 12);
        run_setting(16'hFFFF, 16'd0, 10'd1, 12);
        run_setting(16'd1000, 16'd1000, 10'd512, 12);
        run_setting(16'd0, 16'd1, 10'd1, 12);
        // A zero bar length lies outside the usual range but must still give an empty bar.
        run_setting(16'd100, 16'd200, 10'd0, 12);
        run_setting(16'hFFFE, 16'hFFFF, 10'd1023, 12);
    endtask

    task automatic test_random_stream();
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        repeat (8) begin
            lo = DIST_W'($urandom_range(0, 20000));
            hi = lo + DIST_W'($urandom_range(1, 45535));
            if ($urandom_range(0, 4) == 0) begin
                lo = DIST_W'($urandom);
                hi = DIST_W'($urandom);
            end
            run_setting(lo, hi, BAR_W'($urandom_range(1, 1023)), 32);
        end
    endtask

    task automatic test_output_stall();
        configure(dfdbm_pkg::MIN_DISTANCE_RST, dfdbm_pkg::MAX_DISTANCE_RST,
                  dfdbm_pkg::BAR_PIXELS_RST);
        rx_hold_req = 300;
        repeat (6) send_random_frame();
        settle();
    endtask

    task automatic test_sender_pause();
        repeat (5) send_random_frame();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (5) send_random_frame();
        settle();
    endtask

    task automatic test_steady_flow();
        steady = 1'b1;
        configure(16'd500, 16'd20000, 10'd1000);
        repeat (50) send_random_frame();
        settle();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_frames();
        test_config_extremes();
        test_random_stream();
        test_output_stall();
        test_sender_pause();
        test_steady_flow();
        $display("Sent %0d bytes; checked %0d ok, %0d checksum-error and %0d header-error frames.",
                 bytes_sent, ok_frames, chksum_frames, header_frames);
        $display("Ranges covered full, inverted, equal and narrow spans, bar lengths 0 to 1023.");
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d results still pending.", expected_frames.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== distance_frame_decoder_bar_mapper_unit.f =====
sv/dfdbm_pkg.sv
sv/dfdbm_ctrl.sv
sv/dfdbm_dp.sv
sv/distance_frame_decoder_bar_mapper_unit.sv
sv/dfdbm_checker.sv
tb/sv/tb.sv
